// ===== rtl/tofd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofd_pkg
// Types, constants and the arctangent table of the four-phase demodulator.
// ----------------------------------------------------------------------------
package tofd_pkg;

	localparam int unsigned SqrtSteps = 20;
	localparam int unsigned DivSteps  = 23;
	localparam int unsigned TableLen  = 24;

	localparam logic [30:0] CAir4    = 31'd1198819776;
	localparam logic [22:0] DistMax  = 23'd4795280;
	localparam logic [18:0] AmplMax  = 19'd370728;
	localparam logic [31:0] HalfTurn = 32'h8000_0000;
	localparam logic [31:0] QuartTurn = 32'h4000_0000;
	localparam logic [6:0]  FreqReset = 7'd20;

	typedef struct packed {
		logic signed [36:0] x;
		logic signed [36:0] y;
		logic [31:0]        acc;
		logic               sp;
		logic [31:0]        spv;
	} cord_t;

	typedef struct packed {
		logic [39:0] rad;
		logic [21:0] rem;
		logic [19:0] res;
	} sqrt_t;

	typedef struct packed {
		cord_t       c1;
		cord_t       c2;
		sqrt_t       q1;
		sqrt_t       q2;
		logic [18:0] inten;
	} mid_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [22:0] num;
		logic [22:0] quo;
		logic [16:0] den;
		logic [18:0] ampl;
		logic [18:0] inten;
	} div_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0:  t = 32'h2000_0000;
			5'd1:  t = 32'h12E4_051E;
			5'd2:  t = 32'h09FB_385B;
			5'd3:  t = 32'h0511_11D4;
			5'd4:  t = 32'h028B_0D43;
			5'd5:  t = 32'h0145_D7E1;
			5'd6:  t = 32'h00A2_F61E;
			5'd7:  t = 32'h0051_7C55;
			5'd8:  t = 32'h0028_BE53;
			5'd9:  t = 32'h0014_5F2F;
			5'd10: t = 32'h000A_2F98;
			5'd11: t = 32'h0005_17CC;
			5'd12: t = 32'h0002_8BE6;
			5'd13: t = 32'h0001_45F3;
			5'd14: t = 32'h0000_A2FA;
			5'd15: t = 32'h0000_517D;
			5'd16: t = 32'h0000_28BE;
			5'd17: t = 32'h0000_145F;
			5'd18: t = 32'h0000_0A30;
			5'd19: t = 32'h0000_0518;
			5'd20: t = 32'h0000_028C;
			5'd21: t = 32'h0000_0146;
			5'd22: t = 32'h0000_00A3;
			5'd23: t = 32'h0000_0051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

	function automatic cord_t cord_init(input logic signed [16:0] x, input logic signed [16:0] y);
		cord_t c;
		logic signed [36:0] xs;
		logic signed [36:0] ys;
		xs = {{4{x[16]}}, x, 16'd0};
		ys = {{4{y[16]}}, y, 16'd0};
		c.sp  = 1'b0;
		c.spv = 32'd0;
		if (y == 17'sd0) begin
			c.sp  = 1'b1;
			c.spv = x[16] ? HalfTurn : 32'd0;
		end else if (x == 17'sd0) begin
			c.sp  = 1'b1;
			c.spv = y[16] ? (HalfTurn | QuartTurn) : QuartTurn;
		end
		if (x[16]) begin
			c.x   = -xs;
			c.y   = -ys;
			c.acc = HalfTurn;
		end else begin
			c.x   = xs;
			c.y   = ys;
			c.acc = 32'd0;
		end
		return c;
	endfunction

	function automatic cord_t cord_step(input cord_t c, input logic [4:0] i);
		cord_t n;
		logic signed [36:0] xs;
		logic signed [36:0] ys;
		xs = c.x >>> i;
		ys = c.y >>> i;
		n = c;
		if (!c.y[36]) begin
			n.x   = c.x + ys;
			n.y   = c.y - xs;
			n.acc = c.acc + atan_turn(i);
		end else begin
			n.x   = c.x - ys;
			n.y   = c.y + xs;
			n.acc = c.acc - atan_turn(i);
		end
		return n;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t q, input logic [1:0] rb);
		sqrt_t n;
		logic [21:0] r;
		logic [21:0] t;
		r = {q.rem[19:0], rb};
		t = {q.res, 2'b01};
		n = q;
		if (r >= t) begin
			n.rem = r - t;
			n.res = {q.res[18:0], 1'b1};
		end else begin
			n.rem = r;
			n.res = {q.res[18:0], 1'b0};
		end
		return n;
	endfunction

endpackage

// ===== rtl/tof_four_phase_demodulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_four_phase_demodulator
// Byte-swaps eight phase samples, runs two vectoring CORDICs and two square
// roots side by side, then scales the phase sum to distance by a divider.
// Path: swap, start, CORDIC and root, sum, product, divider and output
// registers. Throughput: one pixel per cycle unless a result waits under
// stall; a stage does at most one CORDIC iteration and one root digit,
// or one quotient bit. The whole pipeline holds while a result waits
// under stall. Reset clears valid bits and sets freq_q to 20 MHz.
// ----------------------------------------------------------------------------
module tof_four_phase_demodulator #(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mod_freq_we,
	input  logic [6:0]  mod_freq_mhz,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [15:0] s1a,
	input  logic [15:0] s2a,
	input  logic [15:0] s3a,
	input  logic [15:0] s4a,
	input  logic [15:0] s1b,
	input  logic [15:0] s2b,
	input  logic [15:0] s3b,
	input  logic [15:0] s4b,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [22:0] distance_q4,
	output logic [18:0] amplitude_q2,
	output logic [18:0] intensity_q3
);

	localparam int unsigned Qs = (CORDIC_STAGES > tofd_pkg::SqrtSteps) ?
		CORDIC_STAGES : tofd_pkg::SqrtSteps;
	localparam int unsigned Ds = tofd_pkg::DivSteps;

	logic        en;
	logic [6:0]  freq_q;
	logic [6:0]  fe;

	logic                v_s1;
	logic signed [16:0]  x1_s1, y1_s1, x2_s1, y2_s1;
	logic [18:0]         inten_s1;

	tofd_pkg::mid_t mid_s [0:Qs];
	logic           mv_s  [0:Qs];

	logic        v_p1;
	logic [33:0] sum_p1;
	logic [18:0] ampl_p1, inten_p1;
	logic        v_p2;
	logic [47:0] pl_p2, ph_p2;
	logic [18:0] ampl_p2, inten_p2;

	tofd_pkg::div_t dv_s [0:Ds];
	logic           dvv_s [0:Ds];

	assign en          = !result_valid || !result_stall;
	assign pixel_stall = !en;
	assign fe          = (freq_q == 7'd0) ? 7'd1 : freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= tofd_pkg::FreqReset;
		end else if (mod_freq_we) begin
			freq_q <= mod_freq_mhz;
		end
	end

	// swap bytes, form the two vectors and the sample sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= $signed({1'b0, s2a[7:0], s2a[15:8]}) - $signed({1'b0, s4a[7:0], s4a[15:8]});
			y1_s1 <= $signed({1'b0, s3a[7:0], s3a[15:8]}) - $signed({1'b0, s1a[7:0], s1a[15:8]});
			x2_s1 <= $signed({1'b0, s2b[7:0], s2b[15:8]}) - $signed({1'b0, s4b[7:0], s4b[15:8]});
			y2_s1 <= $signed({1'b0, s3b[7:0], s3b[15:8]}) - $signed({1'b0, s1b[7:0], s1b[15:8]});
			inten_s1 <= 19'({s1a[7:0], s1a[15:8]}) + 19'({s2a[7:0], s2a[15:8]})
				+ 19'({s3a[7:0], s3a[15:8]}) + 19'({s4a[7:0], s4a[15:8]})
				+ 19'({s1b[7:0], s1b[15:8]}) + 19'({s2b[7:0], s2b[15:8]})
				+ 19'({s3b[7:0], s3b[15:8]}) + 19'({s4b[7:0], s4b[15:8]});
		end
	end

	// squares and CORDIC start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s[0] <= 1'b0;
		end else if (en) begin
			mv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s[0].c1      <= tofd_pkg::cord_init(x1_s1, y1_s1);
			mid_s[0].c2      <= tofd_pkg::cord_init(x2_s1, y2_s1);
			mid_s[0].q1.rad  <= {1'b0, 33'(34'(x1_s1 * x1_s1) + 34'(y1_s1 * y1_s1)), 6'd0};
			mid_s[0].q2.rad  <= {1'b0, 33'(34'(x2_s1 * x2_s1) + 34'(y2_s1 * y2_s1)), 6'd0};
			mid_s[0].q1.rem  <= 22'd0;
			mid_s[0].q1.res  <= 20'd0;
			mid_s[0].q2.rem  <= 22'd0;
			mid_s[0].q2.res  <= 20'd0;
			mid_s[0].inten   <= inten_s1;
		end
	end

	// at most one CORDIC iteration and one root digit per stage
	for (genvar j = 0; j < Qs; j++) begin : g_mid
		tofd_pkg::mid_t nx;

		always_comb begin
			nx = mid_s[j];
			if (j < CORDIC_STAGES && j < tofd_pkg::TableLen) begin
				nx.c1 = tofd_pkg::cord_step(mid_s[j].c1, 5'(j));
				nx.c2 = tofd_pkg::cord_step(mid_s[j].c2, 5'(j));
			end
			if (j < tofd_pkg::SqrtSteps) begin
				nx.q1 = tofd_pkg::sqrt_step(mid_s[j].q1, mid_s[j].q1.rad[39 - 2 * j -: 2]);
				nx.q2 = tofd_pkg::sqrt_step(mid_s[j].q2, mid_s[j].q2.rad[39 - 2 * j -: 2]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[j + 1] <= 1'b0;
			end else if (en) begin
				mv_s[j + 1] <= mv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mid_s[j + 1] <= nx;
			end
		end
	end

	// phase sum and amplitude
	logic [31:0] a1, a2;
	logic [32:0] p1;
	logic [20:0] msum;

	always_comb begin
		a1 = mid_s[Qs].c1.sp ? mid_s[Qs].c1.spv : mid_s[Qs].c1.acc;
		a2 = mid_s[Qs].c2.sp ? mid_s[Qs].c2.spv : mid_s[Qs].c2.acc;
		if (a1 <= tofd_pkg::HalfTurn) begin
			p1 = 33'(a1) + 33'(tofd_pkg::HalfTurn);
		end else begin
			p1 = 33'(a1 - tofd_pkg::HalfTurn);
		end
		msum = 21'(mid_s[Qs].q1.res) + 21'(mid_s[Qs].q2.res) + 21'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p1 <= mv_s[Qs];
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_p1   <= 34'(p1) + 34'(a2);
			ampl_p1  <= (msum[20:2] > tofd_pkg::AmplMax) ? tofd_pkg::AmplMax : msum[20:2];
			inten_p1 <= mid_s[Qs].inten;
			pl_p2    <= 48'(sum_p1[16:0]) * 48'(tofd_pkg::CAir4);
			ph_p2    <= 48'(sum_p1[33:17]) * 48'(tofd_pkg::CAir4);
			ampl_p2  <= ampl_p1;
			inten_p2 <= inten_p1;
		end
	end

	// scale: dist = floor((floor(S*C/2^32) + 500f) / (1000f))
	logic [64:0] prod;
	logic [31:0] num;

	always_comb begin
		prod = {ph_p2, 17'd0} + 65'(pl_p2);
		num  = prod[63:32] + 32'(16'(fe) * 16'd500);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s[0] <= 1'b0;
		end else if (en) begin
			dvv_s[0] <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].rem   <= 18'(num[31:23]);
			dv_s[0].num   <= num[22:0];
			dv_s[0].quo   <= 23'd0;
			dv_s[0].den   <= 17'(fe) * 17'd1000;
			dv_s[0].ampl  <= ampl_p2;
			dv_s[0].inten <= inten_p2;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < Ds; k++) begin : g_div
		tofd_pkg::div_t nd;
		logic [17:0]    r;

		always_comb begin
			nd = dv_s[k];
			r  = {dv_s[k].rem[16:0], dv_s[k].num[Ds - 1 - k]};
			if (r >= 18'(dv_s[k].den)) begin
				nd.rem = r - 18'(dv_s[k].den);
				nd.quo = {dv_s[k].quo[21:0], 1'b1};
			end else begin
				nd.rem = r;
				nd.quo = {dv_s[k].quo[21:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k + 1] <= 1'b0;
			end else if (en) begin
				dvv_s[k + 1] <= dvv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k + 1] <= nd;
			end
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= dvv_s[Ds];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_q4  <= (dv_s[Ds].quo > tofd_pkg::DistMax) ? tofd_pkg::DistMax : dv_s[Ds].quo;
			amplitude_q2 <= dv_s[Ds].ampl;
			intensity_q3 <= dv_s[Ds].inten;
		end
	end

`ifndef SYNTH
	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> distance_q4 <= tofd_pkg::DistMax)
		else $error("distance above saturation limit");

	a_ampl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> amplitude_q2 <= tofd_pkg::AmplMax)
		else $error("amplitude above saturation limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
		result_valid && $stable({distance_q4, amplitude_q2, intensity_q3}))
		else $error("stalled result word changed");
`endif

endmodule
